/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/bvem_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Widths, register indexes, reset values and shared types of the monitor.
// ----------------------------------------------------------------------------
package bvem_pkg;

   // Field and register widths.
   localparam int TimeWidth     = 32;
   localparam int CountWidth    = 16;
   localparam int MvWidth       = 16;
   localparam int ScaleWidth    = 24;
   localparam int AlphaWidth    = 17;
   localparam int IntervalWidth = 16;
   localparam int LimitWidth    = 8;
   localparam int EmaWidth      = 40;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   // Shared multiplier operands: the scale factor by a count, or alpha by half of
   // the difference magnitude.
   localparam int MulAWidth = ScaleWidth;
   localparam int MulBWidth = EmaWidth / 2;
   localparam int ProdWidth = MulAWidth + MulBWidth;

   // Fixed-point constants in Q16.
   localparam int FracBits = 16;
   localparam logic [AlphaWidth-1:0] AlphaOne = AlphaWidth'(65536);
   localparam int HalfLsb = 32768;

   // Defaults of the module parameters.
   localparam int AdcBitsDefault    = 16;
   localparam int QueueDepthDefault = 2;

   // Register reset values.
   localparam logic [ScaleWidth-1:0]    MvPerCountReset = ScaleWidth'(190000);
   localparam logic [AlphaWidth-1:0]    AlphaReset      = AlphaWidth'(6554);
   localparam logic [MvWidth-1:0]       ValidMinReset   = MvWidth'(0);
   localparam logic [MvWidth-1:0]       ValidMaxReset   = MvWidth'(60000);
   localparam logic [IntervalWidth-1:0] IntervalReset   = IntervalWidth'(100);
   localparam logic [LimitWidth-1:0]    FailLimitReset  = LimitWidth'(3);

   // Register indexes of the configuration port.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MV_PER_COUNT  = 3'd0,
      CSR_EMA_ALPHA     = 3'd1,
      CSR_VALID_MIN     = 3'd2,
      CSR_VALID_MAX     = 3'd3,
      CSR_READ_INTERVAL = 3'd4,
      CSR_FAIL_LIMIT    = 3'd5
   } csr_index_type;

   // One classified sample on its way from the front end to the back end.
   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic                  ok;
   } sample_type;

   // Settings that the back end works with.
   typedef struct packed {
      logic [ScaleWidth-1:0] mv_per_count;
      logic [AlphaWidth-1:0] alpha;
      logic [MvWidth-1:0]    valid_min;
      logic [MvWidth-1:0]    valid_max;
      logic [LimitWidth-1:0] fail_limit;
   } back_cfg_type;

endpackage

/* hdl/bvem_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor front end
// Takes requests, drops those inside the read interval and queues the rest.
// ----------------------------------------------------------------------------
module bvem_front
   import bvem_pkg::*;
#(
   parameter int ADC_BITS = AdcBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [TimeWidth-1:0]     req_now_ms,
   input  logic [CountWidth-1:0]    req_adc_count,
   input  logic                     req_read_ok,
   input  logic [IntervalWidth-1:0] read_interval,
   input  logic                     queue_full,
   output logic                     queue_push,
   output sample_type               queue_data
);

   // Largest count the converter can deliver.
   localparam logic [CountWidth-1:0] CountMax = (ADC_BITS >= CountWidth) ?
      {CountWidth{1'b1}} : CountWidth'((1 << ADC_BITS) - 1);

   logic [TimeWidth-1:0] last_time_ff;
   logic [TimeWidth-1:0] last_time_in;
   logic [TimeWidth-1:0] elapsed;
   logic                 accept;
   logic                 due;

   // The queue back-pressures the request channel.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Elapsed time wraps modulo 2^32 like the time stamp itself.
   assign elapsed = req_now_ms - last_time_ff;
   assign due     = elapsed >= TimeWidth'(read_interval);

   assign queue_push = accept && due;
   assign queue_data.ok    = req_read_ok;
   assign queue_data.count = (req_adc_count > CountMax) ? CountMax : req_adc_count;

   // A request that is due restarts the interval.
   always_comb begin
      last_time_in = last_time_ff;
      if (queue_push) begin
         last_time_in = req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
      end else begin
         last_time_ff <= last_time_in;
      end
   end

endmodule

/* hdl/bvem_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor sample queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bvem_queue
   import bvem_pkg::*;
#(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   input  logic       pop,
   output sample_type pop_data,
   output logic       full,
   output logic       empty
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   sample_type            entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CntWidth-1:0]   fill_ff;
   logic [CntWidth-1:0]   fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = fill_ff == FullCnt;
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the fill level tracks both sides.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Sample storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/bvem_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor back end
// Scales, averages, rounds and checks one sample at a time on a shared
// multiplier, and holds the finished response in an output register.
// ----------------------------------------------------------------------------
module bvem_back
   import bvem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  back_cfg_type       cfg,
   input  logic               queue_empty,
   input  sample_type         queue_data,
   output logic               queue_pop,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [MvWidth-1:0] rsp_voltage_mv,
   output logic               rsp_valid_res
);

   typedef enum logic [7:0] {
      BK_IDLE   = 8'b0000_0001,
      BK_SCALE  = 8'b0000_0010,
      BK_DIFF   = 8'b0000_0100,
      BK_MUL_LO = 8'b0000_1000,
      BK_MUL_HI = 8'b0001_0000,
      BK_UPDATE = 8'b0010_0000,
      BK_ROUND  = 8'b0100_0000,
      BK_FINISH = 8'b1000_0000
   } back_state_type;

   localparam int SumWidth = ProdWidth + MulBWidth;
   localparam int RndWidth = EmaWidth + 1;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [EmaWidth-1:0]   raw_ff;
   logic [EmaWidth-1:0]   raw_in;
   logic [EmaWidth-1:0]   ema_ff;
   logic [EmaWidth-1:0]   ema_in;
   logic                  started_ff;
   logic                  started_in;
   logic [MvWidth-1:0]    held_ff;
   logic [MvWidth-1:0]    held_in;
   logic [LimitWidth-1:0] streak_ff;
   logic [LimitWidth-1:0] streak_in;
   logic                  rising_ff;
   logic                  rising_in;
   logic [EmaWidth-1:0]   mag_ff;
   logic [EmaWidth-1:0]   mag_in;
   logic [ProdWidth-1:0]  acc_ff;
   logic [ProdWidth-1:0]  acc_in;
   logic [EmaWidth-1:0]   step_ff;
   logic [EmaWidth-1:0]   step_in;
   logic [MvWidth-1:0]    mv_ff;
   logic [MvWidth-1:0]    mv_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [MvWidth-1:0]    rsp_mv_ff;
   logic                  rsp_res_ff;

   logic [MulAWidth-1:0]  mul_a;
   logic [MulBWidth-1:0]  mul_b;
   logic [ProdWidth-1:0]  mul_p;
   logic [SumWidth-1:0]   step_sum;
   logic [RndWidth-1:0]   rounded;
   logic                  out_free;
   logic                  load_rsp;
   logic                  in_window;

   assign busy           = state_ff != BK_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voltage_mv = rsp_mv_ff;
   assign rsp_valid_res  = rsp_res_ff;

   // Shared multiplier: scale factor by count, then alpha by each half of the
   // difference magnitude.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         BK_SCALE: begin
            mul_a = cfg.mv_per_count;
            mul_b = MulBWidth'(count_ff);
         end
         BK_MUL_LO: begin
            mul_a = MulAWidth'(cfg.alpha);
            mul_b = mag_ff[MulBWidth-1:0];
         end
         BK_MUL_HI: begin
            mul_a = MulAWidth'(cfg.alpha);
            mul_b = mag_ff[EmaWidth-1:MulBWidth];
         end
         default: begin
         end
      endcase
      mul_p = ProdWidth'(mul_a) * ProdWidth'(mul_b);
   end

   // Blend step: both partial products joined, rounded to nearest in Q16.
   assign step_sum = {mul_p, {MulBWidth{1'b0}}} + SumWidth'(acc_ff) + SumWidth'(HalfLsb);

   // Average rounded to whole millivolts.
   assign rounded = {1'b0, ema_ff} + RndWidth'(HalfLsb);

   // Window and fail streak check for the result.
   assign in_window = (streak_ff < cfg.fail_limit) && (mv_ff >= cfg.valid_min) &&
                      (mv_ff <= cfg.valid_max);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == BK_FINISH) && out_free;

   // Sample sequencer.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      raw_in     = raw_ff;
      ema_in     = ema_ff;
      started_in = started_ff;
      held_in    = held_ff;
      streak_in  = streak_ff;
      rising_in  = rising_ff;
      mag_in     = mag_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      mv_in      = mv_ff;
      queue_pop  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               count_in  = queue_data.count;
               if (queue_data.ok) begin
                  streak_in = '0;
                  state_in  = BK_SCALE;
               end else begin
                  // A failed read repeats the last voltage.
                  if (streak_ff != {LimitWidth{1'b1}}) begin
                     streak_in = streak_ff + 1'b1;
                  end
                  mv_in    = held_ff;
                  state_in = BK_FINISH;
               end
            end
         end
         BK_SCALE: begin
            raw_in   = mul_p[EmaWidth-1:0];
            state_in = BK_DIFF;
         end
         BK_DIFF: begin
            if (!started_ff) begin
               // The first good read seeds the average.
               ema_in     = raw_ff;
               started_in = 1'b1;
               state_in   = BK_ROUND;
            end else begin
               rising_in = raw_ff >= ema_ff;
               mag_in    = (raw_ff >= ema_ff) ? raw_ff - ema_ff : ema_ff - raw_ff;
               state_in  = BK_MUL_LO;
            end
         end
         BK_MUL_LO: begin
            acc_in   = mul_p;
            state_in = BK_MUL_HI;
         end
         BK_MUL_HI: begin
            step_in  = step_sum[FracBits +: EmaWidth];
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            ema_in   = rising_ff ? ema_ff + step_ff : ema_ff - step_ff;
            state_in = BK_ROUND;
         end
         BK_ROUND: begin
            if (|rounded[RndWidth-1:FracBits+MvWidth]) begin
               mv_in = {MvWidth{1'b1}};
            end else begin
               mv_in = rounded[FracBits +: MvWidth];
            end
            held_in  = mv_in;
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // The response register is loaded once the previous response is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ema_ff       <= '0;
         started_ff   <= 1'b0;
         held_ff      <= '0;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ema_ff       <= ema_in;
         started_ff   <= started_in;
         held_ff      <= held_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and response payload.
   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      raw_ff    <= raw_in;
      rising_ff <= rising_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      mv_ff     <= mv_in;
      if (load_rsp) begin
         rsp_mv_ff  <= mv_ff;
         rsp_res_ff <= in_window;
      end
   end

endmodule

/* hdl/battery_voltage_ema_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage monitor
// Interval-gated exponential moving average of battery voltage in millivolts.
// ----------------------------------------------------------------------------
// Requests carry a millisecond time stamp, a converter count and a read-ok
// flag; a request moves on req_valid while req_stall is low. A request that
// arrives before the programmed read interval has passed since the last
// counted one gives no response. Every other request gives one response on
// the rsp_ channel: the filtered voltage and a validity flag.
// The front end takes one request per cycle into a short queue; req_stall
// rises only while that queue is full. The back end works one request at a
// time through a shared multiplier: a failed read skips to the response
// register, the seeding read goes through scale, difference and round, and
// each later good read through scale, difference, two partial products,
// update and round. A finished response waits in the output register
// while rsp_stall is high; the queue keeps taking requests meanwhile.
// Registers are written through csr_wr_en, csr_index and csr_wr_data; the
// user must do so only while the block is idle, which it does not enforce.
// Reset restores register defaults, clears the average, the fail streak,
// the interval time and the queue; no response is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_voltage_ema_monitor
   import bvem_pkg::*;
#(
   parameter int ADC_BITS    = AdcBitsDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [TimeWidth-1:0]     req_now_ms,
   input  logic [CountWidth-1:0]    req_adc_count,
   input  logic                     req_read_ok,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MvWidth-1:0]       rsp_voltage_mv,
   output logic                     rsp_valid_res,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data
);

   logic [ScaleWidth-1:0]    mv_per_count_ff;
   logic [AlphaWidth-1:0]    alpha_ff;
   logic [MvWidth-1:0]       valid_min_ff;
   logic [MvWidth-1:0]       valid_max_ff;
   logic [IntervalWidth-1:0] interval_ff;
   logic [LimitWidth-1:0]    fail_limit_ff;

   back_cfg_type back_cfg;
   sample_type   push_data;
   sample_type   pop_data;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   logic         back_busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_per_count_ff <= MvPerCountReset;
         alpha_ff        <= AlphaReset;
         valid_min_ff    <= ValidMinReset;
         valid_max_ff    <= ValidMaxReset;
         interval_ff     <= IntervalReset;
         fail_limit_ff   <= FailLimitReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MV_PER_COUNT:  mv_per_count_ff <= csr_wr_data[ScaleWidth-1:0];
            CSR_EMA_ALPHA:     alpha_ff        <= csr_wr_data[AlphaWidth-1:0];
            CSR_VALID_MIN:     valid_min_ff    <= csr_wr_data[MvWidth-1:0];
            CSR_VALID_MAX:     valid_max_ff    <= csr_wr_data[MvWidth-1:0];
            CSR_READ_INTERVAL: interval_ff     <= csr_wr_data[IntervalWidth-1:0];
            CSR_FAIL_LIMIT:    fail_limit_ff   <= csr_wr_data[LimitWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // Alpha above one blends as one.
   assign back_cfg.mv_per_count = mv_per_count_ff;
   assign back_cfg.alpha        = (alpha_ff > AlphaOne) ? AlphaOne : alpha_ff;
   assign back_cfg.valid_min    = valid_min_ff;
   assign back_cfg.valid_max    = valid_max_ff;
   assign back_cfg.fail_limit   = fail_limit_ff;

   bvem_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_now_ms    (req_now_ms),
      .req_adc_count (req_adc_count),
      .req_read_ok   (req_read_ok),
      .read_interval (interval_ff),
      .queue_full    (q_full),
      .queue_push    (q_push),
      .queue_data    (push_data)
   );

   bvem_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   bvem_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (back_cfg),
      .queue_empty    (q_empty),
      .queue_data     (pop_data),
      .queue_pop      (q_pop),
      .busy           (back_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_valid_res  (rsp_valid_res)
   );

   // Queue and sequencer consistency.
   `ASSERT_ALWAYS(a_no_push_when_full, !(q_push && q_full), "request queued into a full queue")
   `ASSERT_ALWAYS(a_no_pop_when_empty, !(q_pop && q_empty), "sample taken from an empty queue")
   `ASSERT_IMPLIES(a_pop_only_idle, q_pop, !back_busy, "sample taken while back end is busy")
   `ASSERT_IMPLIES(a_rsp_from_back, $rose(rsp_valid), $past(back_busy), "response without work")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage monitor testbench
// Drives time-stamped converter requests into the monitor and checks every
// response against an in-bench model of the interval gate, the averaging
// filter, the fail streak and the validity window. A short table of directed
// requests runs first, and randomized request streams follow under several
// register settings. Requests idle and responses stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import bvem_pkg::*;

   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASES          = 8;
   localparam int PHASE_RESPONSES = 100;
   localparam int DIRECTED_ROWS   = 17;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_QUIET,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      logic [MvWidth-1:0] voltage_mv;
      logic               valid_res;
   } reading_type;

   typedef struct {
      row_kind_type          kind;
      logic [TimeWidth-1:0]  now_ms;
      logic [CountWidth-1:0] adc_count;
      logic                  read_ok;
      logic [MvWidth-1:0]    voltage_mv;
      logic                  valid_res;
   } directed_row_type;

   typedef struct packed {
      logic [ScaleWidth-1:0]    scale;
      logic [AlphaWidth-1:0]    alpha;
      logic [MvWidth-1:0]       min_mv;
      logic [MvWidth-1:0]       max_mv;
      logic [IntervalWidth-1:0] interval;
      logic [LimitWidth-1:0]    limit;
   } setting_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [TimeWidth-1:0]     req_now_ms = '0;
   logic [CountWidth-1:0]    req_adc_count = '0;
   logic                     req_read_ok = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MvWidth-1:0]       rsp_voltage_mv;
   logic                     rsp_valid_res;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wr_data = '0;

   // Register copies and filter state of the in-bench model.
   logic [ScaleWidth-1:0]    cfg_scale;
   logic [AlphaWidth-1:0]    cfg_alpha;
   logic [MvWidth-1:0]       cfg_min_mv;
   logic [MvWidth-1:0]       cfg_max_mv;
   logic [IntervalWidth-1:0] cfg_interval;
   logic [LimitWidth-1:0]    cfg_fail_limit;
   logic [TimeWidth-1:0]     seen_time;
   logic [EmaWidth-1:0]      avg_q16;
   logic                     avg_seeded;
   logic [MvWidth-1:0]       held_mv;
   logic [LimitWidth-1:0]    miss_streak;

   reading_type expected_readings[$];
   reading_type oldest_reading;

   // Traffic control shared between the request and response sides.
   logic idle_on = 1'b0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   stall_left = 0;

   int failures = 0;
   int requests_sent = 0;
   int quiet_requests = 0;
   int readings_checked = 0;

   battery_voltage_ema_monitor i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_now_ms     (req_now_ms),
      .req_adc_count  (req_adc_count),
      .req_read_ok    (req_read_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_voltage_mv (rsp_voltage_mv),
      .rsp_valid_res  (rsp_valid_res),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A reading is valid only outside a fail streak and inside the window.
   function automatic logic in_window(input logic [MvWidth-1:0] mv);
      return (miss_streak < cfg_fail_limit) && (mv >= cfg_min_mv) && (mv <= cfg_max_mv);
   endfunction

   // Advances the model by one request; returns 1 when a response follows.
   function automatic logic predict_reading(input logic [TimeWidth-1:0] now_ms,
                                            input logic [CountWidth-1:0] count,
                                            input logic ok,
                                            output reading_type reading);
      logic [TimeWidth-1:0]  elapsed;
      logic [63:0]           raw_q16;
      logic [63:0]           avg_wide;
      logic [63:0]           gap;
      logic [63:0]           nudge;
      logic [63:0]           rounded;
      logic [AlphaWidth-1:0] weight;
      reading = '0;
      elapsed = now_ms - seen_time;
      if (elapsed < TimeWidth'(cfg_interval)) return 1'b0;
      seen_time = now_ms;

      // A failed read repeats the held voltage and lengthens the streak.
      if (!ok) begin
         if (miss_streak != '1) miss_streak = miss_streak + 1'b1;
         reading.voltage_mv = held_mv;
         reading.valid_res = in_window(held_mv);
         return 1'b1;
      end
      miss_streak = '0;

      // Scale the count, then seed or blend the average.
      raw_q16 = 64'(count) * 64'(cfg_scale);
      avg_wide = 64'(avg_q16);
      if (!avg_seeded) begin
         avg_wide = raw_q16;
         avg_seeded = 1'b1;
      end else begin
         weight = (cfg_alpha > AlphaOne) ? AlphaOne : cfg_alpha;
         if (raw_q16 >= avg_wide) begin
            gap = raw_q16 - avg_wide;
            nudge = (64'(weight) * gap + 64'(HalfLsb)) >> FracBits;
            avg_wide = avg_wide + nudge;
         end else begin
            gap = avg_wide - raw_q16;
            nudge = (64'(weight) * gap + 64'(HalfLsb)) >> FracBits;
            avg_wide = avg_wide - nudge;
         end
      end
      avg_q16 = avg_wide[EmaWidth-1:0];

      // Round to whole millivolts and saturate.
      rounded = (64'(avg_q16) + 64'(HalfLsb)) >> FracBits;
      held_mv = (rounded > 64'd65535) ? '1 : rounded[MvWidth-1:0];
      reading.voltage_mv = held_mv;
      reading.valid_res = in_window(held_mv);
      return 1'b1;
   endfunction

   // Offers one request, waits for it to be taken and records its outcome.
   task automatic send_request(input logic [TimeWidth-1:0] now_ms,
                               input logic [CountWidth-1:0] count,
                               input logic ok,
                               input logic use_typed,
                               input reading_type typed,
                               output logic produced);
      reading_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now_ms;
      req_adc_count <= count;
      req_read_ok <= ok;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      produced = predict_reading(now_ms, count, ok, predicted);
      if (produced) expected_readings.push_back(use_typed ? typed : predicted);
      else quiet_requests++;
   endtask

   // Writes one register and mirrors it into the model.
   task automatic write_register(input csr_index_type idx, input logic [CsrDataWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_MV_PER_COUNT:  cfg_scale = data[ScaleWidth-1:0];
         CSR_EMA_ALPHA:     cfg_alpha = data[AlphaWidth-1:0];
         CSR_VALID_MIN:     cfg_min_mv = data[MvWidth-1:0];
         CSR_VALID_MAX:     cfg_max_mv = data[MvWidth-1:0];
         CSR_READ_INTERVAL: cfg_interval = data[IntervalWidth-1:0];
         CSR_FAIL_LIMIT:    cfg_fail_limit = data[LimitWidth-1:0];
         default: ;
      endcase
   endtask

   // Lets every pending response out, then lets dropped requests settle.
   task automatic wait_idle();
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: check each taken response, then decide the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: response with none expected: voltage_mv %0d valid_res %0b",
                        $realtime, rsp_voltage_mv, rsp_valid_res);
               failures++;
            end else begin
               oldest_reading = expected_readings.pop_front();
               readings_checked++;
               if (rsp_voltage_mv !== oldest_reading.voltage_mv) begin
                  $display("%0t: voltage_mv expected %0d actual %0d",
                           $realtime, oldest_reading.voltage_mv, rsp_voltage_mv);
                  failures++;
               end
               if (rsp_valid_res !== oldest_reading.valid_res) begin
                  $display("%0t: valid_res expected %0b actual %0b",
                           $realtime, oldest_reading.valid_res, rsp_valid_res);
                  failures++;
               end
            end
         end

         // One long hold-off fills the block up; short bursts otherwise.
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      directed_row_type     directed_rows [DIRECTED_ROWS];
      setting_type          fixed_settings [3];
      setting_type          setting;
      reading_type          typed;
      logic [TimeWidth-1:0] stim_time;
      logic [CountWidth-1:0] count;
      logic                 ok;
      logic                 produced;
      int                   phase_responses;
      int                   last_count;
      int                   fail_run;
      int                   pick;
      int                   lo;
      int                   hi;

      // Directed requests under the reset settings.
      directed_rows = '{
         // Too early after time zero: dropped.
         '{ROW_QUIET,   32'd50,          16'd1000,  1'b1, 16'd0,     1'b0},
         // Failed read before any good one: zero, inside the window.
         '{ROW_TYPED,   32'd100,         16'd0,     1'b0, 16'd0,     1'b1},
         // One millisecond short of the interval: dropped.
         '{ROW_QUIET,   32'd199,         16'd5,     1'b1, 16'd0,     1'b0},
         // Full-scale seed saturates and falls above the window.
         '{ROW_TYPED,   32'd200,         16'hFFFF,  1'b1, 16'hFFFF,  1'b0},
         // Failed read holds the saturated value.
         '{ROW_TYPED,   32'd300,         16'd0,     1'b0, 16'hFFFF,  1'b0},
         '{ROW_PREDICT, 32'd400,         16'd0,     1'b1, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'd500,         16'hFFFF,  1'b1, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'd600,         16'd31578, 1'b1, 16'd0,     1'b0},
         // Three failures in a row reach the fail limit.
         '{ROW_PREDICT, 32'd700,         16'd0,     1'b0, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'd800,         16'hFFFF,  1'b0, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'd900,         16'd0,     1'b0, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'd1000,        16'd31578, 1'b1, 16'd0,     1'b0},
         // Time wraps: early, then exactly on the interval, then far ahead.
         '{ROW_PREDICT, 32'hFFFF_FFF0,   16'hFFFF,  1'b1, 16'd0,     1'b0},
         '{ROW_QUIET,   32'h0000_0050,   16'd0,     1'b1, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'h0000_0054,   16'hAAAA,  1'b1, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'h0000_00B8,   16'h5555,  1'b1, 16'd0,     1'b0},
         '{ROW_PREDICT, 32'h8000_0000,   16'hFFFF,  1'b0, 16'd0,     1'b0}
      };

      // Extreme settings; the rest of the phases draw theirs at random.
      fixed_settings[0] = '{scale: 24'd190000, alpha: AlphaOne, min_mv: 16'd0,
                            max_mv: 16'hFFFF, interval: 16'd0, limit: 8'd1};
      fixed_settings[1] = '{scale: 24'hFF_FFFF, alpha: 17'd0, min_mv: 16'hFFFF,
                            max_mv: 16'd0, interval: 16'hFFFF, limit: 8'hFF};
      fixed_settings[2] = '{scale: 24'd0, alpha: 17'h1_FFFF, min_mv: 16'd1000,
                            max_mv: 16'd50000, interval: 16'd1, limit: 8'd0};

      cfg_scale = MvPerCountReset;
      cfg_alpha = AlphaReset;
      cfg_min_mv = ValidMinReset;
      cfg_max_mv = ValidMaxReset;
      cfg_interval = IntervalReset;
      cfg_fail_limit = FailLimitReset;
      seen_time = '0;
      avg_q16 = '0;
      avg_seeded = 1'b0;
      held_mv = '0;
      miss_streak = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      idle_on <= 1'b1;
      foreach (directed_rows[i]) begin
         typed.voltage_mv = directed_rows[i].voltage_mv;
         typed.valid_res = directed_rows[i].valid_res;
         send_request(directed_rows[i].now_ms, directed_rows[i].adc_count,
                      directed_rows[i].read_ok, directed_rows[i].kind == ROW_TYPED,
                      typed, produced);
      end
      req_valid <= 1'b0;
      stim_time = directed_rows[DIRECTED_ROWS-1].now_ms;
      last_count = 0;
      fail_run = 0;
      typed = '0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();

         // Pick this phase's register setting.
         if (phase < 3) begin
            setting = fixed_settings[phase];
         end else begin
            setting.scale = ($urandom_range(0, 1) == 0) ?
                            ScaleWidth'($urandom_range(120000, 260000)) : ScaleWidth'($urandom);
            setting.alpha = ($urandom_range(0, 6) == 0) ?
                            AlphaWidth'($urandom_range(65537, 131071)) :
                            AlphaWidth'($urandom_range(0, 65536));
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
            if ($urandom_range(0, 4) != 0 && lo > hi) begin
               pick = lo;
               lo = hi;
               hi = pick;
            end
            setting.min_mv = MvWidth'(lo);
            setting.max_mv = MvWidth'(hi);
            pick = $urandom_range(0, 9);
            setting.interval = (pick == 0) ? '0 :
                               (pick < 7) ? IntervalWidth'($urandom_range(0, 200)) :
                                            IntervalWidth'($urandom_range(0, 65535));
            setting.limit = ($urandom_range(0, 9) < 7) ? LimitWidth'($urandom_range(0, 6)) :
                                                         LimitWidth'($urandom_range(0, 255));
         end

         write_register(CSR_MV_PER_COUNT, CsrDataWidth'(setting.scale));
         write_register(CSR_EMA_ALPHA, CsrDataWidth'(setting.alpha));
         write_register(CSR_VALID_MIN, CsrDataWidth'(setting.min_mv));
         write_register(CSR_VALID_MAX, CsrDataWidth'(setting.max_mv));
         write_register(CSR_READ_INTERVAL, CsrDataWidth'(setting.interval));
         write_register(CSR_FAIL_LIMIT, CsrDataWidth'(setting.limit));
         csr_wr_en <= 1'b0;

         // The final phase runs with both sides at full speed.
         idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (phase == 0) hold_request <= 1'b1;

         phase_responses = 0;
         while (phase_responses < PHASE_RESPONSES) begin
            // Mostly requests on or after the interval, some early, some jumps.
            pick = $urandom_range(0, 99);
            if (pick < 70)
               stim_time = stim_time + TimeWidth'(cfg_interval) + $urandom_range(0, 40);
            else if (pick < 85)
               stim_time = stim_time +
                           ((cfg_interval == 0) ? 0 : $urandom_range(0, cfg_interval - 1));
            else
               stim_time = $urandom;

            pick = $urandom_range(0, 9);
            if (pick == 0) last_count = 0;
            else if (pick == 1) last_count = 65535;
            else if (pick < 6) last_count = $urandom_range(0, 65535);
            else begin
               last_count = last_count + $urandom_range(0, 1000) - 500;
               if (last_count < 0) last_count = 0;
               if (last_count > 65535) last_count = 65535;
            end
            count = CountWidth'(last_count);

            // Failures come in short runs to exercise the streak limit.
            if (fail_run != 0) begin
               ok = 1'b0;
               fail_run--;
            end else if ($urandom_range(0, 11) == 0) begin
               ok = 1'b0;
               fail_run = $urandom_range(0, 5);
            end else begin
               ok = 1'b1;
            end

            send_request(stim_time, count, ok, 1'b0, typed, produced);
            if (produced) phase_responses++;
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      $display("Sent %0d requests (%0d dropped by the interval gate) under %0d settings,",
               requests_sent, quiet_requests, PHASES + 1);
      $display("checked %0d responses, one long receiver hold-off included.",
               readings_checked);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5000000;
      $display("Timeout with %0d responses still expected", expected_readings.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
